/* src/dmxfr_pkg.sv */
// Shared types and constants for the DMX512 frame repeater.
`timescale 1ns / 1ps

package dmxfr_pkg;

    localparam int CNT_W       = 10;
    localparam int HIST_DEPTH  = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] OP_RX_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_REFRESH = 2'd2;
    localparam logic [1:0] OP_TX_DONE = 2'd3;

    localparam logic [1:0] ACT_NONE       = 2'd0;
    localparam logic [1:0] ACT_BREAK_BYTE = 2'd1;
    localparam logic [1:0] ACT_BYTE       = 2'd2;

    localparam logic [CNT_W-1:0] HIST_RESET   = 10'd512;
    localparam logic [CNT_W-1:0] TIMEOUT_STEP = 10'd35;
    localparam logic [CNT_W-1:0] TIMEOUT_BASE = 10'd4;

    typedef enum logic [2:0] {
        CMD_BREAK,
        CMD_BYTE,
        CMD_TICK,
        CMD_REFRESH,
        CMD_DONE
    } dmxfr_cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BREAK = 2'd1,
        PH_DATA  = 2'd2
    } dmxfr_phase_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
        logic       framing_error;
    } dmxfr_in_t;

    typedef struct packed {
        logic [1:0] tx_action;
        logic [7:0] tx_byte;
        logic       led_on;
        logic       frame_cut;
        logic       tx_enabled;
    } dmxfr_out_t;

    typedef struct packed {
        dmxfr_cmd_t cmd;
        logic [7:0] data;
    } dmxfr_entry_t;

    typedef struct packed {
        logic [1:0] tx_action;
        logic       led_on;
        logic       frame_cut;
        logic       tx_enabled;
        logic       use_mem;
    } dmxfr_stage_t;

endpackage

/* src/dmxfr_front.sv */
// Front end: accept requests, classify them into commands, register them.
`timescale 1ns / 1ps

module dmxfr_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  dmxfr_pkg::dmxfr_in_t   s_req,
    input  logic                   clear_busy,
    output logic                   f_valid,
    input  logic                   f_ready,
    output dmxfr_pkg::dmxfr_entry_t f_entry
);

    logic                    valid_reg;
    logic                    valid_next;
    dmxfr_pkg::dmxfr_entry_t entry_reg;
    dmxfr_pkg::dmxfr_entry_t entry_class;
    logic                    take;

    assign s_ready = !clear_busy && (!valid_reg || f_ready);
    assign take    = s_valid && s_ready;

    always_comb begin
        entry_class.data = s_req.rx_byte;
        unique case (s_req.operation)
            dmxfr_pkg::OP_RX_BYTE: begin
                entry_class.cmd = s_req.framing_error ? dmxfr_pkg::CMD_BREAK
                                                      : dmxfr_pkg::CMD_BYTE;
            end
            dmxfr_pkg::OP_TICK:    entry_class.cmd = dmxfr_pkg::CMD_TICK;
            dmxfr_pkg::OP_REFRESH: entry_class.cmd = dmxfr_pkg::CMD_REFRESH;
            default:               entry_class.cmd = dmxfr_pkg::CMD_DONE;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (f_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            entry_reg <= entry_class;
        end
    end

    assign f_valid = valid_reg;
    assign f_entry = entry_reg;

endmodule

/* src/dmxfr_queue.sv */
// Short command queue between the front end and the execution unit.
`timescale 1ns / 1ps

module dmxfr_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  dmxfr_pkg::dmxfr_entry_t push_entry,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output dmxfr_pkg::dmxfr_entry_t pop_entry
);

    localparam int PTR_W = $clog2(dmxfr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dmxfr_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(dmxfr_pkg::QUEUE_DEPTH);

    dmxfr_pkg::dmxfr_entry_t slots_reg [dmxfr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* src/dmxfr_back.sv */
// Execution unit: receive/transmit state, slot store, result pipeline.
`timescale 1ns / 1ps

module dmxfr_back #(
    parameter int MAX_SLOTS = 512
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [3:0]              cfg_wr_data,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  dmxfr_pkg::dmxfr_entry_t q_entry,
    output logic                    clear_busy,
    output logic                    m_valid,
    input  logic                    m_ready,
    output dmxfr_pkg::dmxfr_out_t   m_req
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int CW = dmxfr_pkg::CNT_W;
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_SLOTS);
    localparam logic [AW-1:0] LAST_ADR = AW'(MAX_SLOTS - 1);

    logic [7:0] mem [MAX_SLOTS];
    logic [7:0] rdata_reg;

    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clr_adr_reg, clr_adr_next;

    logic [3:0] tsel_reg;

    dmxfr_pkg::dmxfr_phase_t phase_reg, phase_next;
    logic          tx_active_reg, tx_active_next;
    logic [CW-1:0] rx_cnt_reg, rx_cnt_next;
    logic [CW-1:0] prev_cnt_reg, prev_cnt_next;
    logic [CW-1:0] tx_idx_reg, tx_idx_next;
    logic [CW-1:0] last_idx_reg, last_idx_next;
    logic [CW-1:0] ticks_reg, ticks_next;
    logic [CW-1:0] hist_reg [dmxfr_pkg::HIST_DEPTH];
    logic [CW-1:0] hist_next [dmxfr_pkg::HIST_DEPTH];
    logic [1:0]    hptr_reg, hptr_next;
    logic          enable_reg, enable_next;
    logic          led_reg, led_next;

    logic          s2_valid_reg, s2_valid_next;
    dmxfr_pkg::dmxfr_stage_t s2_reg, s2_result;
    logic          m_valid_reg, m_valid_next;
    dmxfr_pkg::dmxfr_out_t m_req_reg;

    logic          out_free, s2_free, fire;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wadr;
    logic [7:0]    mem_wdata;

    logic [CW-1:0] len, tick_inc, threshold;
    logic [SW-1:0] hist_sum, len_x3, sum_diff;
    logic          avg_match, stalled_rx, slot_room;

    assign out_free   = !m_valid_reg || m_ready;
    assign s2_free    = !s2_valid_reg || out_free;
    assign q_ready    = s2_free && !clearing_reg;
    assign fire       = q_valid && q_ready;
    assign clear_busy = clearing_reg;

    assign len        = (rx_cnt_reg == '0) ? '0 : CW'(rx_cnt_reg - 1'b1);
    assign tick_inc   = CW'(ticks_reg + 1'b1);
    assign threshold  = CW'(dmxfr_pkg::TIMEOUT_STEP * CW'(tsel_reg)) + dmxfr_pkg::TIMEOUT_BASE;
    assign stalled_rx = (prev_cnt_reg == rx_cnt_reg) && (phase_reg == dmxfr_pkg::PH_DATA);
    assign slot_room  = (rx_cnt_reg < MAX_CNT);

    always_comb begin
        for (int k = 0; k < dmxfr_pkg::HIST_DEPTH; k++) begin
            hist_next[k] = (hptr_reg == 2'(k)) ? len : hist_reg[k];
        end
        hist_sum  = SW'(hist_next[0]) + SW'(hist_next[1]) + SW'(hist_next[2]);
        len_x3    = SW'(len) + SW'({len, 1'b0});
        sum_diff  = SW'(hist_sum - len_x3);
        avg_match = (hist_sum >= len_x3) && (sum_diff < SW'(dmxfr_pkg::HIST_DEPTH));
    end

    always_comb begin
        phase_next = phase_reg;
        if (fire) begin
            unique case (q_entry.cmd)
                dmxfr_pkg::CMD_BREAK: begin
                    phase_next = (phase_reg == dmxfr_pkg::PH_DATA) ? dmxfr_pkg::PH_IDLE
                                                                   : dmxfr_pkg::PH_BREAK;
                end
                dmxfr_pkg::CMD_BYTE: begin
                    if (phase_reg == dmxfr_pkg::PH_DATA) begin
                        if (!slot_room) begin
                            phase_next = dmxfr_pkg::PH_IDLE;
                        end
                    end else if (phase_reg != dmxfr_pkg::PH_IDLE) begin
                        phase_next = (q_entry.data == 8'd0) ? dmxfr_pkg::PH_DATA
                                                            : dmxfr_pkg::PH_IDLE;
                    end
                end
                dmxfr_pkg::CMD_TICK: begin
                    if (stalled_rx) begin
                        phase_next = dmxfr_pkg::PH_IDLE;
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    always_comb begin
        tx_active_next = tx_active_reg;
        rx_cnt_next    = rx_cnt_reg;
        prev_cnt_next  = prev_cnt_reg;
        tx_idx_next    = tx_idx_reg;
        last_idx_next  = last_idx_reg;
        ticks_next     = ticks_reg;
        hptr_next      = hptr_reg;
        enable_next    = enable_reg;
        led_next       = led_reg;
        s2_result      = '0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wadr       = rx_cnt_reg[AW-1:0];
        mem_wdata      = q_entry.data;
        if (fire) begin
            case (q_entry.cmd)
                dmxfr_pkg::CMD_BREAK: begin
                    if (phase_reg == dmxfr_pkg::PH_DATA) begin
                        s2_result.frame_cut = 1'b1;
                        led_next            = 1'b0;
                    end
                end
                dmxfr_pkg::CMD_BYTE: begin
                    if (phase_reg == dmxfr_pkg::PH_DATA) begin
                        if (slot_room) begin
                            mem_we      = 1'b1;
                            rx_cnt_next = CW'(rx_cnt_reg + 1'b1);
                        end
                    end else if (phase_reg != dmxfr_pkg::PH_IDLE) begin
                        hptr_next   = (hptr_reg == 2'(dmxfr_pkg::HIST_DEPTH - 1)) ? 2'd0
                                                                         : 2'(hptr_reg + 1'b1);
                        if (avg_match) begin
                            last_idx_next = len;
                        end
                        enable_next = 1'b1;
                        ticks_next  = '0;
                        rx_cnt_next = '0;
                    end
                end
                dmxfr_pkg::CMD_TICK: begin
                    ticks_next = tick_inc;
                    if (tick_inc >= threshold) begin
                        enable_next    = 1'b0;
                        ticks_next     = '0;
                        tx_active_next = 1'b0;
                        led_next       = 1'b0;
                    end
                    if (stalled_rx) begin
                        led_next = 1'b1;
                    end else begin
                        prev_cnt_next = rx_cnt_reg;
                    end
                end
                dmxfr_pkg::CMD_REFRESH: begin
                    if (!tx_active_reg && enable_reg) begin
                        led_next            = 1'b1;
                        tx_idx_next         = '0;
                        tx_active_next      = 1'b1;
                        s2_result.tx_action = dmxfr_pkg::ACT_BREAK_BYTE;
                    end
                end
                default: begin
                    if (tx_active_reg) begin
                        if (tx_idx_reg <= last_idx_reg && tx_idx_reg < MAX_CNT) begin
                            s2_result.tx_action = dmxfr_pkg::ACT_BYTE;
                            s2_result.use_mem   = 1'b1;
                            mem_re              = 1'b1;
                            tx_idx_next         = CW'(tx_idx_reg + 1'b1);
                        end else begin
                            tx_active_next = 1'b0;
                        end
                    end
                end
            endcase
        end
        if (clearing_reg) begin
            mem_we    = 1'b1;
            mem_wadr  = clr_adr_reg;
            mem_wdata = 8'd0;
        end
        s2_result.led_on     = led_next;
        s2_result.tx_enabled = enable_next;
    end

    always_comb begin
        clearing_next = clearing_reg;
        clr_adr_next  = clr_adr_reg;
        if (clearing_reg) begin
            clr_adr_next = AW'(clr_adr_reg + 1'b1);
            if (clr_adr_reg == LAST_ADR) begin
                clearing_next = 1'b0;
            end
        end
        s2_valid_next = s2_valid_reg;
        if (fire) begin
            s2_valid_next = 1'b1;
        end else if (out_free) begin
            s2_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s2_valid_reg && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_adr_reg   <= '0;
            tsel_reg      <= '0;
            phase_reg     <= dmxfr_pkg::PH_IDLE;
            tx_active_reg <= 1'b0;
            rx_cnt_reg    <= '0;
            prev_cnt_reg  <= '0;
            tx_idx_reg    <= '0;
            last_idx_reg  <= '0;
            ticks_reg     <= '0;
            for (int k = 0; k < dmxfr_pkg::HIST_DEPTH; k++) begin
                hist_reg[k] <= dmxfr_pkg::HIST_RESET;
            end
            hptr_reg      <= '0;
            enable_reg    <= 1'b0;
            led_reg       <= 1'b0;
            s2_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            clearing_reg  <= clearing_next;
            clr_adr_reg   <= clr_adr_next;
            if (cfg_wr_en) begin
                tsel_reg <= cfg_wr_data;
            end
            phase_reg     <= phase_next;
            tx_active_reg <= tx_active_next;
            rx_cnt_reg    <= rx_cnt_next;
            prev_cnt_reg  <= prev_cnt_next;
            tx_idx_reg    <= tx_idx_next;
            last_idx_reg  <= last_idx_next;
            ticks_reg     <= ticks_next;
            if (fire && q_entry.cmd == dmxfr_pkg::CMD_BYTE
                && phase_reg != dmxfr_pkg::PH_DATA && phase_reg != dmxfr_pkg::PH_IDLE) begin
                for (int k = 0; k < dmxfr_pkg::HIST_DEPTH; k++) begin
                    hist_reg[k] <= hist_next[k];
                end
            end
            hptr_reg      <= hptr_next;
            enable_reg    <= enable_next;
            led_reg       <= led_next;
            s2_valid_reg  <= s2_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wadr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[tx_idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            s2_reg <= s2_result;
        end
        if (s2_valid_reg && out_free) begin
            m_req_reg.tx_action  <= s2_reg.tx_action;
            m_req_reg.tx_byte    <= s2_reg.use_mem ? rdata_reg : 8'd0;
            m_req_reg.led_on     <= s2_reg.led_on;
            m_req_reg.frame_cut  <= s2_reg.frame_cut;
            m_req_reg.tx_enabled <= s2_reg.tx_enabled;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_req   = m_req_reg;

endmodule

/* src/dmx512_frame_repeater.sv */
// Top level of the DMX512 frame repeater: front end, command queue, execution unit.
//
//   channel  direction  handshake           payload
//   s_       in         s_valid / s_ready   s_req  (event: operation, byte, break flag)
//   m_       out        m_valid / m_ready   m_req  (transmit action, byte, status)
//   cfg_     in         cfg_wr_en           cfg_wr_data (timeout select)
//
// One request per cycle unless m_ready stalls or the slot store is being cleared.
// The slot store has one write and one read port; each event does at most one access.
// After reset the slot store is zeroed with s_ready held low.
// Either side may stall: the four-entry queue and output register decouple them.
`timescale 1ns / 1ps

module dmx512_frame_repeater #(
    parameter int MAX_SLOTS = 512
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [3:0]            cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dmxfr_pkg::dmxfr_in_t  s_req,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dmxfr_pkg::dmxfr_out_t m_req
);

    logic                    clear_busy;
    logic                    f_valid, f_ready;
    dmxfr_pkg::dmxfr_entry_t f_entry;
    logic                    q_valid, q_ready;
    dmxfr_pkg::dmxfr_entry_t q_entry;

    dmxfr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .clear_busy (clear_busy),
        .f_valid    (f_valid),
        .f_ready    (f_ready),
        .f_entry    (f_entry)
    );

    dmxfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_entry (f_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_entry  (q_entry)
    );

    dmxfr_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_entry     (q_entry),
        .clear_busy  (clear_busy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_req       (m_req)
    );

endmodule

/* bench/dmx512_frame_repeater_tb.sv */
// Self-checking bench for the DMX512 frame repeater: event streams checked against a predictor.
`timescale 1ns / 1ps

module dmx512_frame_repeater_tb;

    localparam int SLOTS       = 512;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE      = 8;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [3:0]            cfg_wr_data = 4'd0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    dmxfr_pkg::dmxfr_in_t  s_req       = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    dmxfr_pkg::dmxfr_out_t m_req;

    dmx512_frame_repeater #(
        .MAX_SLOTS(SLOTS)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_req      (m_req)
    );

    // Predicted repeater state
    logic [3:0]                  timeout_sel;
    dmxfr_pkg::dmxfr_phase_t     rx_phase;
    logic                        tx_active;
    logic [7:0]                  slots [SLOTS];
    logic [dmxfr_pkg::CNT_W-1:0] rx_count;
    logic [dmxfr_pkg::CNT_W-1:0] prev_rx_count;
    logic [dmxfr_pkg::CNT_W-1:0] tx_index;
    logic [dmxfr_pkg::CNT_W-1:0] last_index;
    logic [dmxfr_pkg::CNT_W-1:0] ticks;
    logic [dmxfr_pkg::CNT_W-1:0] len_hist [dmxfr_pkg::HIST_DEPTH];
    int                          hist_ptr;
    logic                        enabled;
    logic                        led;

    dmxfr_pkg::dmxfr_in_t  event_q[$];
    dmxfr_pkg::dmxfr_out_t response_q[$];
    dmxfr_pkg::dmxfr_out_t want;
    int         queued;
    int         fail_count;
    int         burst_left;
    int         gap_left;
    int         ready_mode;
    int         mode_left;
    int         cyc;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic dmxfr_pkg::dmxfr_out_t expected_response(dmxfr_pkg::dmxfr_in_t ev);
        dmxfr_pkg::dmxfr_out_t       r;
        logic [dmxfr_pkg::CNT_W-1:0] len;
        int                          sum;
        r = '0;
        case (ev.operation)
            dmxfr_pkg::OP_RX_BYTE: begin
                if (ev.framing_error) begin
                    if (rx_phase != dmxfr_pkg::PH_DATA) begin
                        rx_phase = dmxfr_pkg::PH_BREAK;
                    end else begin
                        rx_phase    = dmxfr_pkg::PH_IDLE;
                        r.frame_cut = 1'b1;
                        led         = 1'b0;
                    end
                end else if (rx_phase == dmxfr_pkg::PH_DATA) begin
                    if (rx_count < SLOTS) begin
                        slots[rx_count] = ev.rx_byte;
                        rx_count        = rx_count + 1'b1;
                    end else begin
                        rx_phase = dmxfr_pkg::PH_IDLE;
                    end
                end else if (rx_phase != dmxfr_pkg::PH_IDLE) begin
                    len = (rx_count == 0) ? '0 : rx_count - 1'b1;
                    len_hist[hist_ptr] = len;
                    hist_ptr = (hist_ptr + 1) % dmxfr_pkg::HIST_DEPTH;
                    sum = 0;
                    foreach (len_hist[k])
                        sum += int'(len_hist[k]);
                    if (int'(len) == sum / dmxfr_pkg::HIST_DEPTH)
                        last_index = len;
                    enabled  = 1'b1;
                    ticks    = '0;
                    rx_count = '0;
                    rx_phase = (ev.rx_byte == 8'd0) ? dmxfr_pkg::PH_DATA : dmxfr_pkg::PH_IDLE;
                end
            end
            dmxfr_pkg::OP_TICK: begin
                ticks = ticks + 1'b1;
                if (int'(ticks) >= int'(dmxfr_pkg::TIMEOUT_STEP) * int'(timeout_sel)
                                   + int'(dmxfr_pkg::TIMEOUT_BASE)) begin
                    enabled   = 1'b0;
                    ticks     = '0;
                    tx_active = 1'b0;
                    led       = 1'b0;
                end
                if (prev_rx_count == rx_count && rx_phase == dmxfr_pkg::PH_DATA) begin
                    rx_phase = dmxfr_pkg::PH_IDLE;
                    led      = 1'b1;
                end else begin
                    prev_rx_count = rx_count;
                end
            end
            dmxfr_pkg::OP_REFRESH: begin
                if (!tx_active && enabled) begin
                    led         = 1'b1;
                    tx_index    = '0;
                    tx_active   = 1'b1;
                    r.tx_action = dmxfr_pkg::ACT_BREAK_BYTE;
                    r.tx_byte   = 8'h00;
                end
            end
            dmxfr_pkg::OP_TX_DONE: begin
                if (tx_active) begin
                    if (tx_index <= last_index && tx_index < SLOTS) begin
                        r.tx_action = dmxfr_pkg::ACT_BYTE;
                        r.tx_byte   = slots[tx_index];
                        tx_index    = tx_index + 1'b1;
                    end else begin
                        tx_active = 1'b0;
                    end
                end
            end
        endcase
        r.led_on     = led;
        r.tx_enabled = enabled;
        return r;
    endfunction

    // Sender: bursts of requests separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_req      <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_valid && s_ready)
                response_q.push_back(expected_response(s_req));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (event_q.size() > 0) begin
                    s_valid <= 1'b1;
                    s_req   <= event_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        case ($urandom_range(0, 2))
                            0: gap_left <= 0;
                            1: gap_left <= $urandom_range(1, 4);
                            default: gap_left <= $urandom_range(5, 24);
                        endcase
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each response, stall in changing patterns
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_mode <= 0;
            mode_left  <= 0;
            cyc        <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (response_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected response action=%0d byte=%02h", $realtime,
                                 m_req.tx_action, m_req.tx_byte);
                end else begin
                    want = response_q.pop_front();
                    if (m_req.tx_action !== want.tx_action || m_req.tx_byte !== want.tx_byte ||
                        m_req.led_on !== want.led_on || m_req.frame_cut !== want.frame_cut ||
                        m_req.tx_enabled !== want.tx_enabled) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch: expected act=%0d byte=%02h led=%0b cut=%0b en=%0b",
                                     $realtime, want.tx_action, want.tx_byte, want.led_on,
                                     want.frame_cut, want.tx_enabled);
                            $display("%0t:                got act=%0d byte=%02h led=%0b cut=%0b en=%0b",
                                     $realtime, m_req.tx_action, m_req.tx_byte, m_req.led_on,
                                     m_req.frame_cut, m_req.tx_enabled);
                        end
                    end
                end
            end
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (cyc[3:0] < 4);
            endcase
            cyc <= cyc + 1;
        end
    end

    task automatic push_event(logic [1:0] op, logic [7:0] data, logic fe);
        dmxfr_pkg::dmxfr_in_t ev;
        ev.operation     = op;
        ev.rx_byte       = data;
        ev.framing_error = fe;
        event_q.push_back(ev);
        queued++;
    endtask

    task automatic push_frame(int n, logic [7:0] code, bit mixed);
        push_event(dmxfr_pkg::OP_RX_BYTE, 8'($urandom), 1'b1);
        push_event(dmxfr_pkg::OP_RX_BYTE, code, 1'b0);
        for (int i = 0; i < n; i++) begin
            push_event(dmxfr_pkg::OP_RX_BYTE, 8'($urandom), 1'b0);
            if (mixed) begin
                case ($urandom_range(0, 31))
                    0, 1: push_event(dmxfr_pkg::OP_TICK, 8'($urandom), 1'($urandom));
                    2, 3, 4, 5: push_event(dmxfr_pkg::OP_TX_DONE, 8'($urandom), 1'($urandom));
                    6: push_event(dmxfr_pkg::OP_REFRESH, 8'($urandom), 1'($urandom));
                    default: ;
                endcase
            end
        end
    endtask

    task automatic push_playback(int n);
        push_event(dmxfr_pkg::OP_REFRESH, 8'($urandom), 1'($urandom));
        repeat (n) push_event(dmxfr_pkg::OP_TX_DONE, 8'($urandom), 1'($urandom));
    endtask

    task automatic push_traffic(int n, int typ);
        int stop;
        int roll;
        int k;
        stop = queued + n;
        while (queued < stop) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                k = ($urandom_range(0, 3) != 0) ? typ : $urandom_range(0, 40);
                push_frame(k, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                           1'b1);
            end else if (roll < 65) begin
                push_playback($urandom_range(0, typ + 4));
            end else if (roll < 80) begin
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
                repeat (k) push_event(dmxfr_pkg::OP_TICK, 8'($urandom), 1'($urandom));
            end else begin
                repeat ($urandom_range(1, 4))
                    push_event(2'($urandom), 8'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic drain_block();
        while (event_q.size() > 0 || s_valid || response_q.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_timeout(logic [3:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        timeout_sel = v;
        @(negedge aclk);
    endtask

    initial begin
        timeout_sel   = 4'd0;
        rx_phase      = dmxfr_pkg::PH_IDLE;
        tx_active     = 1'b0;
        rx_count      = '0;
        prev_rx_count = '0;
        tx_index      = '0;
        last_index    = '0;
        ticks         = '0;
        hist_ptr      = 0;
        enabled       = 1'b0;
        led           = 1'b0;
        queued        = 0;
        fail_count    = 0;
        foreach (slots[i])
            slots[i] = 8'h00;
        foreach (len_hist[i])
            len_hist[i] = dmxfr_pkg::HIST_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        write_timeout(4'd0);
        push_event(dmxfr_pkg::OP_TX_DONE, 8'h00, 1'b0);
        push_event(dmxfr_pkg::OP_REFRESH, 8'hFF, 1'b1);
        push_event(dmxfr_pkg::OP_RX_BYTE, 8'hFF, 1'b0);
        push_event(dmxfr_pkg::OP_RX_BYTE, 8'hAA, 1'b1);
        // start code after an empty frame
        push_event(dmxfr_pkg::OP_RX_BYTE, 8'h00, 1'b0);
        push_event(dmxfr_pkg::OP_RX_BYTE, 8'h00, 1'b0);
        push_event(dmxfr_pkg::OP_RX_BYTE, 8'hFF, 1'b0);
        push_event(dmxfr_pkg::OP_RX_BYTE, 8'h5A, 1'b0);
        push_event(dmxfr_pkg::OP_RX_BYTE, 8'h00, 1'b1);
        push_event(dmxfr_pkg::OP_RX_BYTE, 8'hFF, 1'b1);
        push_event(dmxfr_pkg::OP_RX_BYTE, 8'h00, 1'b0);
        push_event(dmxfr_pkg::OP_RX_BYTE, 8'h81, 1'b0);
        push_event(dmxfr_pkg::OP_RX_BYTE, 8'h7E, 1'b0);
        // stall the data so the receiver drops back to idle
        push_event(dmxfr_pkg::OP_TICK, 8'h00, 1'b0);
        push_event(dmxfr_pkg::OP_TICK, 8'hFF, 1'b1);
        // non-zero start code, history wraps and the lengths agree
        push_event(dmxfr_pkg::OP_RX_BYTE, 8'h00, 1'b1);
        push_event(dmxfr_pkg::OP_RX_BYTE, 8'h55, 1'b0);
        push_playback(4);
        push_event(dmxfr_pkg::OP_REFRESH, 8'h00, 1'b0);
        // time out in the middle of a transmitted frame
        repeat (4) push_event(dmxfr_pkg::OP_TICK, 8'h00, 1'b0);
        push_event(dmxfr_pkg::OP_TX_DONE, 8'h00, 1'b0);
        drain_block();

        write_timeout(4'd15);
        push_traffic(125, $urandom_range(0, 24));
        drain_block();

        write_timeout(4'($urandom_range(1, 14)));
        push_traffic(125, $urandom_range(0, 24));
        drain_block();

        write_timeout(4'd1);
        push_traffic(125, $urandom_range(0, 24));
        drain_block();

        write_timeout(4'd0);
        push_traffic(125, $urandom_range(0, 24));
        drain_block();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* dmx512_frame_repeater.f */
src/dmxfr_pkg.sv
src/dmxfr_front.sv
src/dmxfr_queue.sv
src/dmxfr_back.sv
src/dmx512_frame_repeater.sv
bench/dmx512_frame_repeater_tb.sv
